>>> rtl/core/dtpc_pkg.sv
// Package for the digit trie prefix checker: sizes of the node table,
// transaction kind codes and the row type of the child memory.
// Used by digit_trie_prefix_check; depends on nothing.
package dtpc_pkg;

    localparam int MAX_NODES = 4096;
    localparam int RADIX     = 10;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int KIND_W  = 2;
    localparam int DIGIT_W = 4;
    localparam int SLOT_W  = (RADIX > 1) ? $clog2(RADIX) : 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // One row per node: the child index for every digit, zero meaning none.
    typedef logic [RADIX-1:0][NODE_W-1:0] t_child_row;

endpackage

>>> rtl/core/digit_trie_prefix_check.sv
// Digit trie prefix checker: node table in two synchronous memories,
// walk control and sticky flags. Depends on dtpc_pkg.
//
//  channel   direction   signals                               payload
//  input     in          i_in_valid / o_in_stall               i_kind, i_digit, i_last
//  output    out         o_out_valid / i_out_stall             o_prefix_hit,
//                                                              o_any_conflict, o_pool_full
//
// In a transaction the accepting edge reads the current node's row, and
// the next cycle evaluates it and writes back. An insert that takes a fresh node
// then passes through the S_ZERO state, which initializes that node's row. After reset
// the block initializes the root row in its S_INIT state, with o_in_stall
// high. Nodes are handed out in order, so the allocation count marks which rows are
// live and no wider clearing pass is needed; a clear transaction resets the count
// and rewrites the root row in its write cycle. A stalled output holds the block in
// its evaluate cycle, and no new transaction is accepted until the result is stored.
module digit_trie_prefix_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dtpc_pkg::KIND_W-1:0]   i_kind,
    input  logic [dtpc_pkg::DIGIT_W-1:0]  i_digit,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_prefix_hit,
    output logic                          o_any_conflict,
    output logic                          o_pool_full
);
    import dtpc_pkg::*;

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_EXEC = 4'b0100,
        S_ZERO = 4'b1000
    } t_state;

    // Node table storage.
    t_child_row mem_child [MAX_NODES];
    logic       mem_end   [MAX_NODES];

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_cursor, n_cursor;
    logic [CNT_W-1:0]    r_used, n_used;
    logic                r_hit, n_hit;
    logic                r_lost, n_lost;
    logic                r_conf, n_conf;
    logic                r_pool, n_pool;
    logic [NODE_W-1:0]   r_new, n_new;
    logic                r_new_end, n_new_end;
    logic                r_out_valid;

    logic [KIND_W-1:0]   r_kind;
    logic [DIGIT_W-1:0]  r_digit;
    logic                r_last;
    logic                r_o_hit, r_o_conf, r_o_pool;

    t_child_row          r_child_rd;
    logic                r_end_rd;

    logic                child_we;
    logic [NODE_W-1:0]   child_addr;
    t_child_row          child_data;
    logic                end_we;
    logic [NODE_W-1:0]   end_addr;
    logic                end_data;

    logic                out_free;
    logic                exec_fire;
    logic                out_hit;
    logic                digit_ok;
    logic [SLOT_W-1:0]   slot;
    logic [NODE_W-1:0]   next_node;
    logic                alloc;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_prefix_hit   = r_o_hit;
    assign o_any_conflict = r_o_conf;
    assign o_pool_full    = r_o_pool;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign digit_ok  = (r_digit < DIGIT_W'(RADIX));
    assign slot      = digit_ok ? r_digit[SLOT_W-1:0] : '0;
    assign next_node = r_child_rd[slot];

    // The memories read the current node every cycle; the row seen in the
    // evaluate cycle is the one addressed at the accepting edge.
    always_ff @(posedge i_clk) begin
        if (child_we) begin
            mem_child[child_addr] <= child_data;
        end
        r_child_rd <= mem_child[r_cursor];
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            mem_end[end_addr] <= end_data;
        end
        r_end_rd <= mem_end[r_cursor];
    end

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_used     = r_used;
        n_hit      = r_hit;
        n_lost     = r_lost;
        n_conf     = r_conf;
        n_pool     = r_pool;
        n_new      = r_new;
        n_new_end  = r_new_end;
        out_hit    = 1'b0;
        exec_fire  = 1'b0;
        alloc      = 1'b0;
        child_we   = 1'b0;
        child_addr = r_cursor;
        child_data = r_child_rd;
        end_we     = 1'b0;
        end_addr   = r_cursor;
        end_data   = 1'b0;

        case (r_state)
            S_INIT: begin
                child_we   = 1'b1;
                child_addr = '0;
                child_data = '0;
                end_we     = 1'b1;
                end_addr   = '0;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    exec_fire = 1'b1;
                    n_state   = S_IDLE;
                    case (r_kind)
                        KIND_INSERT: begin
                            if (!r_lost) begin
                                if (!digit_ok) begin
                                    n_lost = 1'b1;
                                end else if (next_node != '0) begin
                                    n_cursor = next_node;
                                end else if (r_used < CNT_W'(MAX_NODES)) begin
                                    // Link a fresh node; its own row is set up next cycle.
                                    alloc            = 1'b1;
                                    n_cursor         = r_used[NODE_W-1:0];
                                    n_used           = r_used + CNT_W'(1);
                                    child_we         = 1'b1;
                                    child_data[slot] = r_used[NODE_W-1:0];
                                end else begin
                                    n_pool = 1'b1;
                                    n_lost = 1'b1;
                                end
                            end
                            n_new     = r_used[NODE_W-1:0];
                            n_new_end = r_last && alloc;
                            if (r_last) begin
                                // A fresh node gets its end mark with its row setup.
                                if (!n_lost && !alloc) begin
                                    end_we   = 1'b1;
                                    end_addr = n_cursor;
                                    end_data = 1'b1;
                                end
                                n_cursor = '0;
                                n_hit    = 1'b0;
                                n_lost   = 1'b0;
                            end
                            if (alloc) begin
                                n_state = S_ZERO;
                            end
                        end
                        KIND_QUERY: begin
                            if (!r_lost) begin
                                if (r_end_rd) begin
                                    n_hit = 1'b1;
                                end
                                if (!digit_ok || next_node == '0) begin
                                    n_lost = 1'b1;
                                end else begin
                                    n_cursor = next_node;
                                end
                            end
                            if (r_last) begin
                                out_hit = n_hit;
                                if (n_hit) begin
                                    n_conf = 1'b1;
                                end
                                n_cursor = '0;
                                n_hit    = 1'b0;
                                n_lost   = 1'b0;
                            end
                        end
                        KIND_CLEAR: begin
                            child_we   = 1'b1;
                            child_addr = '0;
                            child_data = '0;
                            end_we     = 1'b1;
                            end_addr   = '0;
                            n_used     = CNT_W'(1);
                            n_conf     = 1'b0;
                            n_pool     = 1'b0;
                            n_cursor   = '0;
                            n_hit      = 1'b0;
                            n_lost     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ZERO: begin
                child_we   = 1'b1;
                child_addr = r_new;
                child_data = '0;
                end_we     = 1'b1;
                end_addr   = r_new;
                end_data   = r_new_end;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cursor    <= '0;
            r_used      <= CNT_W'(1);
            r_hit       <= 1'b0;
            r_lost      <= 1'b0;
            r_conf      <= 1'b0;
            r_pool      <= 1'b0;
            r_new       <= '0;
            r_new_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_used    <= n_used;
            r_hit     <= n_hit;
            r_lost    <= n_lost;
            r_conf    <= n_conf;
            r_pool    <= n_pool;
            r_new     <= n_new;
            r_new_end <= n_new_end;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction and result payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_kind  <= i_kind;
            r_digit <= i_digit;
            r_last  <= i_last;
        end
        if (exec_fire) begin
            r_o_hit  <= out_hit;
            r_o_conf <= n_conf;
            r_o_pool <= n_pool;
        end
    end

endmodule
